/* hdl/mhic_pkg.sv */
// Shared types, constants and a helper function for the hard-iron calibrator.
package mhic_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned AddrBits = 3;
  localparam int unsigned DataBits = 32;

  localparam logic [TimeBits-1:0] DefaultWindowUs = TimeBits'(30000000);

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [OffsetBits-1:0] offset_t;

  typedef enum logic {
    KindSample = 1'b0,
    KindStart  = 1'b1
  } kind_e;

  typedef enum logic {
    RegWindowLength = 1'b0,
    RegOffsetEnable = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic                kind;
    logic [TimeBits-1:0] time_us;
    sample_t             sample_x;
    sample_t             sample_y;
    sample_t             sample_z;
  } in_beat_t;

  typedef struct packed {
    sample_t field_x;
    sample_t field_y;
    sample_t field_z;
    logic    healthy;
    logic    calibrating;
    logic    calibration_done;
    offset_t offset_x_out;
    offset_t offset_y_out;
    offset_t offset_z_out;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic track;
    logic close;
    logic offset_en;
  } lane_ctrl_t;

  function automatic offset_t to_offset(sample_t v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[OffsetBits-1:0];
  endfunction

endpackage

/* hdl/mhic_window.sv */
// Calibration window timer: tracks the window start time and open flag.
module mhic_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                start_i,
  input  logic [mhic_pkg::TimeBits-1:0]       time_us_i,
  input  logic [mhic_pkg::TimeBits-1:0]       window_length_i,
  input  logic                                offset_en_i,
  output mhic_pkg::lane_ctrl_t                ctrl_o,
  output logic                                open_d_o,
  output logic                                done_o
);

  logic [mhic_pkg::TimeBits-1:0] start_time_q, start_time_d;
  logic                          open_q, open_d;
  logic [mhic_pkg::TimeBits-1:0] elapsed;
  logic                          in_window;
  logic                          track, close;

  always_comb begin
    elapsed = time_us_i - start_time_q;
    in_window = elapsed < window_length_i;
    track = !start_i && open_q && in_window;
    close = !start_i && open_q && !in_window;
    start_time_d = start_i ? time_us_i : start_time_q;
    if (start_i) begin
      open_d = 1'b1;
    end else if (close) begin
      open_d = 1'b0;
    end else begin
      open_d = open_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      open_q <= 1'b0;
    end else if (accept_i) begin
      start_time_q <= start_time_d;
      open_q <= open_d;
    end
  end

  assign ctrl_o = '{accept: accept_i, start: start_i, track: track, close: close,
                    offset_en: offset_en_i};
  assign open_d_o = open_d;
  assign done_o = close;

endmodule

/* hdl/mhic_lane.sv */
// One axis lane: offset correction, min/max tracking and midpoint offset.
module mhic_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mhic_pkg::lane_ctrl_t ctrl_i,
  input  mhic_pkg::sample_t    sample_i,
  output mhic_pkg::sample_t    field_o,
  output mhic_pkg::offset_t    offset_o,
  output logic                 nonzero_o
);

  localparam int unsigned SB = mhic_pkg::SampleBits;

  mhic_pkg::sample_t offset_q, offset_d;
  mhic_pkg::sample_t low_q, low_d;
  mhic_pkg::sample_t high_q, high_d;
  mhic_pkg::sample_t last_q, last_d;

  logic signed [SB:0] diff;
  logic signed [SB:0] sum;
  logic signed [SB:0] half;
  mhic_pkg::sample_t  corrected;

  always_comb begin
    diff = (SB+1)'(sample_i) - (SB+1)'(offset_q);
    if (!ctrl_i.offset_en) begin
      corrected = sample_i;
    end else if (diff > (SB+1)'(signed'({1'b0, {(SB-1){1'b1}}}))) begin
      corrected = {1'b0, {(SB-1){1'b1}}};
    end else if (diff < (SB+1)'(signed'({1'b1, {(SB-1){1'b0}}}))) begin
      corrected = {1'b1, {(SB-1){1'b0}}};
    end else begin
      corrected = diff[SB-1:0];
    end

    sum = (SB+1)'(low_q) + (SB+1)'(high_q);
    half = (sum + (SB+1)'(sum[SB])) >>> 1;

    last_d = ctrl_i.start ? last_q : corrected;
    offset_d = offset_q;
    low_d = low_q;
    high_d = high_q;
    if (ctrl_i.start) begin
      offset_d = '0;
      low_d = last_q;
      high_d = last_q;
    end else if (ctrl_i.close) begin
      offset_d = half[SB-1:0];
    end else if (ctrl_i.track) begin
      if (corrected < low_q) begin
        low_d = corrected;
      end
      if (corrected > high_q) begin
        high_d = corrected;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      low_q <= '0;
      high_q <= '0;
      last_q <= '0;
    end else if (ctrl_i.accept) begin
      offset_q <= offset_d;
      low_q <= low_d;
      high_q <= high_d;
      last_q <= last_d;
    end
  end

  assign field_o = last_d;
  assign offset_o = mhic_pkg::to_offset(offset_d);
  assign nonzero_o = last_d != '0;

endmodule

/* hdl/magnetometer_hard_iron_calibrator_unit.sv */
// The three axis lanes and the window timer work in parallel; each result beat is
// registered when its input beat is accepted, one beat per cycle unless stalled.
// The output register is the only stage, so input stalls only while a result waits.
// Reset clears offsets, min/max, last field values and the window, and loads
// the window length with 30000000 us and offset use with off.
module magnetometer_hard_iron_calibrator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mhic_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mhic_pkg::out_beat_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mhic_pkg::AddrBits-1:0]       paddr,
  input  logic [mhic_pkg::DataBits-1:0]       pwdata,
  output logic [mhic_pkg::DataBits-1:0]       prdata,
  output logic                                pready
);

  logic [mhic_pkg::TimeBits-1:0] window_length_q;
  logic                          offset_enable_q;
  mhic_pkg::reg_index_e          reg_index;
  logic                          cfg_write;

  logic                          accept;
  logic                          start;
  mhic_pkg::lane_ctrl_t          ctrl;
  logic                          open_d;
  logic                          done;

  mhic_pkg::sample_t             lane_sample [mhic_pkg::NumAxes];
  mhic_pkg::sample_t             lane_field [mhic_pkg::NumAxes];
  mhic_pkg::offset_t             lane_offset [mhic_pkg::NumAxes];
  logic [mhic_pkg::NumAxes-1:0]  lane_nonzero;

  logic                          out_valid_q;
  mhic_pkg::out_beat_t           out_data_q, out_data_d;

  assign pready = 1'b1;
  assign reg_index = mhic_pkg::reg_index_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= mhic_pkg::DefaultWindowUs;
      offset_enable_q <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index)
        mhic_pkg::RegWindowLength: window_length_q <= pwdata;
        mhic_pkg::RegOffsetEnable: offset_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      mhic_pkg::RegWindowLength: prdata = window_length_q;
      mhic_pkg::RegOffsetEnable: prdata = {{(mhic_pkg::DataBits-1){1'b0}}, offset_enable_q};
      default: prdata = '0;
    endcase
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;
  assign start = in_data_i.kind == mhic_pkg::KindStart;

  mhic_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .start_i        (start),
    .time_us_i      (in_data_i.time_us),
    .window_length_i(window_length_q),
    .offset_en_i    (offset_enable_q),
    .ctrl_o         (ctrl),
    .open_d_o       (open_d),
    .done_o         (done)
  );

  assign lane_sample[0] = in_data_i.sample_x;
  assign lane_sample[1] = in_data_i.sample_y;
  assign lane_sample[2] = in_data_i.sample_z;

  for (genvar a = 0; a < mhic_pkg::NumAxes; a++) begin : g_lane
    mhic_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (lane_sample[a]),
      .field_o  (lane_field[a]),
      .offset_o (lane_offset[a]),
      .nonzero_o(lane_nonzero[a])
    );
  end

  always_comb begin
    out_data_d.field_x = lane_field[0];
    out_data_d.field_y = lane_field[1];
    out_data_d.field_z = lane_field[2];
    out_data_d.healthy = &lane_nonzero;
    out_data_d.calibrating = open_d;
    out_data_d.calibration_done = done;
    out_data_d.offset_x_out = lane_offset[0];
    out_data_d.offset_y_out = lane_offset[1];
    out_data_d.offset_z_out = lane_offset[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

/* tb/sv/magnetometer_hard_iron_calibrator_unit_checker.sv */
// Checker that predicts the hard-iron calibrator's result beats and compares them with the block.
module magnetometer_hard_iron_calibrator_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  mhic_pkg::in_beat_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  mhic_pkg::out_beat_t           out_data_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [mhic_pkg::AddrBits-1:0] paddr_i,
  input  logic [mhic_pkg::DataBits-1:0] pwdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  import mhic_pkg::*;

  localparam int FieldMax = 2 ** (SampleBits - 1) - 1;
  localparam int FieldMin = -FieldMax - 1;

  logic [TimeBits-1:0] window_len;
  logic                offset_use;
  offset_t             axis_offset [NumAxes];
  sample_t             axis_low [NumAxes];
  sample_t             axis_high [NumAxes];
  sample_t             last_field [NumAxes];
  logic [TimeBits-1:0] window_start;
  logic                window_active;
  out_beat_t           corrected_beats_q [$];
  int                  mismatches;

  task automatic correct_and_track(input in_beat_t beat, output out_beat_t res);
    sample_t             raw [NumAxes];
    logic [TimeBits-1:0] elapsed;
    int                  v;
    int                  a;
    logic                closed;
    raw[0] = beat.sample_x;
    raw[1] = beat.sample_y;
    raw[2] = beat.sample_z;
    closed = 1'b0;
    if (kind_e'(beat.kind) == KindStart) begin
      window_start = beat.time_us;
      window_active = 1'b1;
      for (a = 0; a < NumAxes; a++) begin
        axis_offset[a] = '0;
        axis_low[a] = last_field[a];
        axis_high[a] = last_field[a];
      end
    end else begin
      for (a = 0; a < NumAxes; a++) begin
        v = int'(raw[a]);
        if (offset_use) begin
          v = v - int'(axis_offset[a]);
          if (v > FieldMax) begin
            v = FieldMax;
          end else if (v < FieldMin) begin
            v = FieldMin;
          end
        end
        last_field[a] = sample_t'(v);
      end
      if (window_active) begin
        elapsed = beat.time_us - window_start;
        if (elapsed < window_len) begin
          for (a = 0; a < NumAxes; a++) begin
            if (last_field[a] < axis_low[a]) begin
              axis_low[a] = last_field[a];
            end
            if (last_field[a] > axis_high[a]) begin
              axis_high[a] = last_field[a];
            end
          end
        end else begin
          window_active = 1'b0;
          closed = 1'b1;
          for (a = 0; a < NumAxes; a++) begin
            axis_offset[a] = offset_t'((int'(axis_low[a]) + int'(axis_high[a])) / 2);
          end
        end
      end
    end
    res.field_x = last_field[0];
    res.field_y = last_field[1];
    res.field_z = last_field[2];
    res.healthy = (last_field[0] != 0) && (last_field[1] != 0) && (last_field[2] != 0);
    res.calibrating = window_active;
    res.calibration_done = closed;
    res.offset_x_out = axis_offset[0];
    res.offset_y_out = axis_offset[1];
    res.offset_z_out = axis_offset[2];
  endtask

  task automatic check_field(input string name, input logic [SampleBits-1:0] want,
                             input logic [SampleBits-1:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      window_len = DefaultWindowUs;
      offset_use = 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
        axis_offset[a] = '0;
        axis_low[a] = '0;
        axis_high[a] = '0;
        last_field[a] = '0;
      end
      window_start = '0;
      window_active = 1'b0;
      corrected_beats_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (corrected_beats_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("result beat with no prediction waiting: %h", out_data_i);
          end
          mismatches++;
        end else begin
          want = corrected_beats_q.pop_front();
          check_field("field_x", want.field_x, out_data_i.field_x);
          check_field("field_y", want.field_y, out_data_i.field_y);
          check_field("field_z", want.field_z, out_data_i.field_z);
          check_field("healthy", SampleBits'(want.healthy),
                      SampleBits'(out_data_i.healthy));
          check_field("calibrating", SampleBits'(want.calibrating),
                      SampleBits'(out_data_i.calibrating));
          check_field("calibration_done", SampleBits'(want.calibration_done),
                      SampleBits'(out_data_i.calibration_done));
          check_field("offset_x_out", want.offset_x_out, out_data_i.offset_x_out);
          check_field("offset_y_out", want.offset_y_out, out_data_i.offset_y_out);
          check_field("offset_z_out", want.offset_z_out, out_data_i.offset_z_out);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        correct_and_track(in_data_i, want);
        corrected_beats_q.push_back(want);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_index_e'(paddr_i[AddrBits-1:2]))
          RegWindowLength: begin
            window_len = pwdata_i[TimeBits-1:0];
          end
          RegOffsetEnable: begin
            offset_use = pwdata_i[0];
          end
          default: begin
          end
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o <= corrected_beats_q.size();
  end

endmodule

/* tb/sv/magnetometer_hard_iron_calibrator_unit_tb.sv */
// Testbench top for the hard-iron calibrator: stimulus, flow control, watchdog and verdict.
module magnetometer_hard_iron_calibrator_unit_tb;

  import mhic_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int StallLimit = 5000;
  localparam sample_t FieldTop = sample_t'(2 ** (SampleBits - 1) - 1);
  localparam sample_t FieldBottom = sample_t'(-(2 ** (SampleBits - 1)));

  logic                clk_i;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_beat_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;

  int                  sent;
  int                  in_gap_pct;
  int                  out_gap_pct;
  logic                hold_off_req;
  logic [TimeBits-1:0] clock_us;
  int                  idle_cycles;

  magnetometer_hard_iron_calibrator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  magnetometer_hard_iron_calibrator_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic in_beat_t field_beat(input logic [TimeBits-1:0] t, input sample_t x,
                                          input sample_t y, input sample_t z);
    in_beat_t b;
    b.kind = KindSample;
    b.time_us = t;
    b.sample_x = x;
    b.sample_y = y;
    b.sample_z = z;
    return b;
  endfunction

  function automatic in_beat_t start_beat(input logic [TimeBits-1:0] t);
    in_beat_t b;
    b.kind = KindStart;
    b.time_us = t;
    b.sample_x = sample_t'($urandom());
    b.sample_y = sample_t'($urandom());
    b.sample_z = sample_t'($urandom());
    return b;
  endfunction

  function automatic sample_t pick_field(input int centre, input int radius);
    case ($urandom_range(0, 19))
      0: begin
        return sample_t'($urandom());
      end
      1: begin
        return $urandom_range(0, 1) ? FieldTop : FieldBottom;
      end
      2: begin
        return '0;
      end
      default: begin
        return sample_t'(centre + int'($urandom_range(0, 2 * radius)) - radius);
      end
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b);
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [DataBits-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrBits'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic configure(input logic [TimeBits-1:0] win, input logic en);
    settle();
    write_reg(RegWindowLength, DataBits'(win));
    write_reg(RegOffsetEnable, DataBits'(en));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(input int items, input logic [TimeBits-1:0] win, input logic en,
                           input int in_pct, input int out_pct, input logic hold);
    int                  target;
    int                  k;
    int                  a;
    int                  centre [NumAxes];
    int                  radius;
    logic [TimeBits-1:0] stride;
    logic [TimeBits-1:0] opened;
    in_beat_t            b;
    configure(win, en);
    if (hold) begin
      hold_off_req = 1'b1;
    end
    in_gap_pct = in_pct;
    out_gap_pct = out_pct;
    target = sent + items;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        for (a = 0; a < NumAxes; a++) begin
          centre[a] = int'($urandom_range(0, 60000)) - 30000;
        end
        radius = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20000));
        opened = clock_us;
        send_beat(start_beat(clock_us));
        k = $urandom_range(2, 20);
        stride = win / k;
        repeat (k) begin
          clock_us = clock_us + $urandom_range(0, stride);
          if ($urandom_range(0, 19) == 0) begin
            opened = clock_us;
            send_beat(start_beat(clock_us));
          end else begin
            send_beat(field_beat(clock_us, pick_field(centre[0], radius),
                                 pick_field(centre[1], radius),
                                 pick_field(centre[2], radius)));
          end
        end
        clock_us = opened + win + $urandom_range(0, 3);
        send_beat(field_beat(clock_us, pick_field(centre[0], radius),
                             pick_field(centre[1], radius), pick_field(centre[2], radius)));
        repeat ($urandom_range(1, 6)) begin
          clock_us = clock_us + $urandom_range(0, 1000);
          send_beat(field_beat(clock_us, pick_field(centre[0], radius),
                               pick_field(centre[1], radius),
                               pick_field(centre[2], radius)));
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          b.kind = $urandom_range(0, 1) ? KindStart : KindSample;
          b.time_us = $urandom();
          b.sample_x = sample_t'($urandom());
          b.sample_y = sample_t'($urandom());
          b.sample_z = sample_t'($urandom());
          send_beat(b);
        end
        clock_us = $urandom();
      end
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < out_gap_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[magnetometer_hard_iron_calibrator_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sent = 0;
    in_gap_pct = 0;
    out_gap_pct = 0;
    hold_off_req = 1'b0;
    clock_us = '0;
    idle_cycles <= 0;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    configure(32'd1000, 1'b0);
    send_beat(field_beat(32'd5, FieldTop, FieldBottom, '0));
    send_beat(field_beat(32'd6, -16'sd1, 16'sd1, FieldBottom));
    send_beat(start_beat(32'd0));
    send_beat(field_beat(32'd10, 16'sd100, -16'sd200, 16'sd300));
    send_beat(field_beat(32'd999, -16'sd100, 16'sd200, -16'sd300));
    send_beat(field_beat(32'd1000, 16'sd7, 16'sd7, 16'sd7));

    configure(32'd1000, 1'b1);
    send_beat(start_beat(32'd2000));
    send_beat(field_beat(32'd2001, 16'sd30000, -16'sd30000, FieldTop));
    send_beat(start_beat(32'd2002));
    send_beat(field_beat(32'd2003, FieldTop, FieldBottom, 16'sd20000));
    send_beat(field_beat(32'd3002, 16'sd1, 16'sd1, 16'sd1));
    send_beat(field_beat(32'd3003, FieldBottom, FieldTop, FieldBottom));
    send_beat(field_beat(32'd3004, '0, '0, '0));

    configure(32'd0, 1'b1);
    send_beat(start_beat(32'hFFFF_FFF0));
    send_beat(field_beat(32'hFFFF_FFF0, 16'sd3, -16'sd3, 16'sd9));

    configure(32'hFFFF_FFFF, 1'b1);
    send_beat(start_beat(32'hFFFF_FFF0));
    send_beat(field_beat(32'd5, FieldBottom, FieldBottom, FieldBottom));
    send_beat(field_beat(32'hFFFF_FFEF, FieldTop, 16'sd1, -16'sd1));

    configure(DefaultWindowUs, 1'b0);
    send_beat(field_beat($urandom(), sample_t'($urandom()), sample_t'($urandom()),
                         sample_t'($urandom())));

    run_phase(300, 32'($urandom_range(1, 2000)), 1'b1, 20, 20, 1'b0);
    run_phase(200, 32'd1, 1'b1, 0, 25, 1'b0);
    run_phase(250, 32'hFFFF_FFFF, 1'($urandom_range(0, 1)), 15, 0, 1'b1);
    run_phase(200, DefaultWindowUs, 1'b0, 30, 30, 1'b0);
    run_phase(350, 32'($urandom_range(1, 100000)), 1'b1, 40, 40, 1'b0);
    run_phase(300, 32'($urandom_range(1, 2000)), 1'b1, 0, 0, 1'b0);

    settle();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[magnetometer_hard_iron_calibrator_unit] OK");
    end else begin
      $display("[magnetometer_hard_iron_calibrator_unit] ERROR");
    end
    $finish;
  end

endmodule

/* magnetometer_hard_iron_calibrator_unit.f */
hdl/mhic_pkg.sv
hdl/mhic_window.sv
hdl/mhic_lane.sv
hdl/magnetometer_hard_iron_calibrator_unit.sv
tb/sv/magnetometer_hard_iron_calibrator_unit_checker.sv
tb/sv/magnetometer_hard_iron_calibrator_unit_tb.sv
